// ----- src/fixed_capacity_multiset_top_macros.svh -----
// Assertion macros shared by the multiset block.
// Included by the top level; depends on a clock i_clk and reset i_rst_n in scope.
`ifndef FIXED_CAPACITY_MULTISET_TOP_MACROS_SVH
`define FIXED_CAPACITY_MULTISET_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FCM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/fcm_pkg.sv -----
// Types and helpers for the fixed-capacity multiset block.
// No dependencies; used by the top level, the checker and the testbench.
package fcm_pkg;

    // Operation codes carried in the input tuser.
    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_COUNT  = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    // Controller states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_MOVE = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // Result beat, ok in the lowest bit.
    typedef struct packed {
        logic       empty_res;
        logic [4:0] size;
        logic [4:0] frequency;
        logic       ok;
    } t_result;

    localparam int RESULT_W = $bits(t_result);
    localparam int TDATA_OUT_W = ((RESULT_W + 7) / 8) * 8;

    // Clamp a count to the 5-bit result field.
    function automatic logic [4:0] sat5(input logic [31:0] v);
        logic [4:0] r;
        r = (v > 32'd31) ? 5'd31 : v[4:0];
        return r;
    endfunction

endpackage

// ----- src/fixed_capacity_multiset_top.sv -----
// Fixed-capacity multiset: entries in a dense RAM, scanned one per cycle.
// An add or clear goes straight to the result state; count and remove scan the entries first
// when the bag is not empty, and a remove that leaves a hole moves the last entry into it.
// A new item is accepted only when idle, after the previous result beat has been registered.
// Reset (synchronous, active low) clears the entry count and the output; the RAM
// contents are not cleared, only entries below the count are ever used.
// Depends on fcm_pkg, fcm_ram and fixed_capacity_multiset_top_macros.svh.
`include "fixed_capacity_multiset_top_macros.svh"

module fixed_capacity_multiset_top #(
    parameter int CAPACITY    = 16,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [31:0]                     i_s_axis_tdata,  // [31:0] value
    input  logic [1:0]                      i_s_axis_tuser,  // [1:0] func
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [0] ok, [5:1] frequency, [10:6] size, [11] empty_res, rest zero
    output logic [fcm_pkg::TDATA_OUT_W-1:0] o_m_axis_tdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    fcm_pkg::t_state  r_state, n_state;
    fcm_pkg::t_func   r_func, n_func;
    logic [ENTRY_WIDTH-1:0] r_value, n_value;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_cmp_idx, n_cmp_idx;
    logic [CW-1:0]    r_freq, n_freq;
    logic             r_ok, n_ok;
    logic             r_out_valid, n_out_valid;
    fcm_pkg::t_result r_out, n_out;

    logic                   w_accept;
    logic [63:0]            w_value64;
    logic [ENTRY_WIDTH-1:0] w_value;
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [AW-1:0]          w_raddr;
    logic [ENTRY_WIDTH-1:0] w_wdata;
    logic [ENTRY_WIDTH-1:0] w_rdata;
    logic                   w_match;
    logic [CW-1:0]          w_last_idx;
    logic                   w_last;
    logic [CW-1:0]          w_next_idx;
    logic                   w_in_scan;
    logic                   w_in_move;
    logic                   w_in_done;
    logic                   w_wr_state;

    // Entry storage.
    fcm_ram #(
        .WIDTH(ENTRY_WIDTH),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Input value reduced to the entry width.
    assign w_value64 = {32'd0, i_s_axis_tdata};
    assign w_value   = w_value64[ENTRY_WIDTH-1:0];

    assign o_s_axis_tready = (r_state == fcm_pkg::S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Scan bookkeeping: compare the entry read last cycle, step to the next.
    assign w_match    = (w_rdata == r_value);
    assign w_last_idx = r_count - CW'(1);
    assign w_last     = (r_cmp_idx == w_last_idx);
    assign w_next_idx = r_cmp_idx + CW'(1);

    // Controller.
    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_value     = r_value;
        n_count     = r_count;
        n_cmp_idx   = r_cmp_idx;
        n_freq      = r_freq;
        n_ok        = r_ok;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_we        = 1'b0;
        w_waddr     = r_count[AW-1:0];
        w_wdata     = w_value;
        w_raddr     = '0;

        // Downstream takes the pending result beat.
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            fcm_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_func  = fcm_pkg::t_func'(i_s_axis_tuser);
                    n_value = w_value;
                    n_freq  = '0;
                    unique case (fcm_pkg::t_func'(i_s_axis_tuser))
                        fcm_pkg::FUNC_ADD: begin
                            if (r_count < CW'(CAPACITY)) begin
                                w_we    = 1'b1;
                                n_count = r_count + CW'(1);
                                n_ok    = 1'b1;
                            end else begin
                                n_ok = 1'b0;
                            end
                            n_state = fcm_pkg::S_DONE;
                        end
                        fcm_pkg::FUNC_REMOVE, fcm_pkg::FUNC_COUNT: begin
                            n_cmp_idx = '0;
                            if (r_count == '0) begin
                                n_ok    = 1'b0;
                                n_state = fcm_pkg::S_DONE;
                            end else begin
                                n_state = fcm_pkg::S_SCAN;
                            end
                        end
                        fcm_pkg::FUNC_CLEAR: begin
                            n_count = '0;
                            n_ok    = 1'b1;
                            n_state = fcm_pkg::S_DONE;
                        end
                        default: begin
                            n_state = fcm_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            fcm_pkg::S_SCAN: begin
                w_raddr = w_next_idx[AW-1:0];
                if (r_func == fcm_pkg::FUNC_REMOVE) begin
                    if (w_match) begin
                        // Found: shrink, and fill the hole from the last entry.
                        n_count = w_last_idx;
                        n_ok    = 1'b1;
                        if (w_last) begin
                            n_state = fcm_pkg::S_DONE;
                        end else begin
                            w_raddr = w_last_idx[AW-1:0];
                            n_state = fcm_pkg::S_MOVE;
                        end
                    end else if (w_last) begin
                        n_ok    = 1'b0;
                        n_state = fcm_pkg::S_DONE;
                    end else begin
                        n_cmp_idx = w_next_idx;
                    end
                end else begin
                    n_freq = r_freq + CW'(w_match);
                    if (w_last) begin
                        n_ok    = (n_freq != '0);
                        n_state = fcm_pkg::S_DONE;
                    end else begin
                        n_cmp_idx = w_next_idx;
                    end
                end
            end
            fcm_pkg::S_MOVE: begin
                w_we    = 1'b1;
                w_waddr = r_cmp_idx[AW-1:0];
                w_wdata = w_rdata;
                n_state = fcm_pkg::S_DONE;
            end
            fcm_pkg::S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out.ok        = r_ok;
                    n_out.frequency = fcm_pkg::sat5(32'(r_freq));
                    n_out.size      = fcm_pkg::sat5(32'(r_count));
                    n_out.empty_res = (r_count == '0);
                    n_out_valid     = 1'b1;
                    n_state         = fcm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fcm_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fcm_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_value   <= n_value;
        r_cmp_idx <= n_cmp_idx;
        r_freq    <= n_freq;
        r_ok      <= n_ok;
        r_out     <= n_out;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(fcm_pkg::TDATA_OUT_W - fcm_pkg::RESULT_W){1'b0}}, r_out};

    // State decodes used by the checks below.
    assign w_in_scan  = (r_state == fcm_pkg::S_SCAN);
    assign w_in_move  = (r_state == fcm_pkg::S_MOVE);
    assign w_in_done  = (r_state == fcm_pkg::S_DONE);
    assign w_wr_state = (r_state == fcm_pkg::S_IDLE) || w_in_move;

    // Checks on the controller.
    `FCM_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(CAPACITY), "entry count above capacity")
    `FCM_ASSERT_NOW(a_write_state, w_we, w_wr_state, "RAM write outside add or move")
    `FCM_ASSERT_NOW(a_scan_range, w_in_scan, r_cmp_idx < r_count, "scan index past last entry")
    `FCM_ASSERT_NEXT(a_move_done, w_in_move, w_in_done, "move not followed by result")

endmodule

// ----- src/fcm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fcm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- dv/multiset_checker.sv -----
// Checker for the fixed-capacity multiset: watches the input and result channels,
// keeps its own copy of the bag to predict each result beat, and compares fields.
// Depends on fcm_pkg for the operation codes and the result layout.
module multiset_checker #(
    parameter int CAPACITY    = 16,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [31:0]                     i_s_tdata,   // [31:0] value
    input  logic [1:0]                      i_s_tuser,   // [1:0] func
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // [0] ok, [5:1] frequency, [10:6] size, [11] empty_res, rest zero
    input  logic [fcm_pkg::TDATA_OUT_W-1:0] i_m_tdata,
    output int                              o_fail_count,
    output int                              o_pending
);

    // Bits of the value that the bag actually stores.
    localparam logic [31:0] VALUE_MASK =
        (ENTRY_WIDTH >= 32) ? '1 : ((32'd1 << ENTRY_WIDTH) - 32'd1);

    logic [31:0]                     bag_entries [CAPACITY];
    int                              bag_size;
    fcm_pkg::t_result                expected_results [$];
    int                              fail_count = 0;
    fcm_pkg::t_result                got;
    fcm_pkg::t_result                want;
    fcm_pkg::t_result                predicted;
    logic [fcm_pkg::TDATA_OUT_W-1:0] pad_bits;

    // Counts are reported in 5-bit fields and stick at the top value.
    function automatic logic [4:0] clamp_count(int n);
        return (n > 31) ? 5'd31 : 5'(n);
    endfunction

    // Apply one operation to the bag copy and return the result it gives.
    function automatic fcm_pkg::t_result bag_predict(fcm_pkg::t_func func,
                                                     logic [31:0] raw_value);
        logic [31:0]      v;
        fcm_pkg::t_result r;
        int               hits;
        int               pos;
        int               i;
        v    = raw_value & VALUE_MASK;
        r    = '0;
        hits = 0;
        pos  = -1;
        case (func)
            fcm_pkg::FUNC_ADD: begin
                if (bag_size < CAPACITY) begin
                    bag_entries[bag_size] = v;
                    bag_size++;
                    r.ok = 1'b1;
                end
            end
            fcm_pkg::FUNC_REMOVE: begin
                // First match wins; the last entry fills the hole.
                for (i = 0; i < bag_size; i++) begin
                    if (pos < 0 && bag_entries[i] == v) pos = i;
                end
                if (pos >= 0) begin
                    bag_size--;
                    bag_entries[pos] = bag_entries[bag_size];
                    r.ok = 1'b1;
                end
            end
            fcm_pkg::FUNC_COUNT: begin
                for (i = 0; i < bag_size; i++) begin
                    if (bag_entries[i] == v) hits++;
                end
                r.ok        = (hits > 0);
                r.frequency = clamp_count(hits);
            end
            default: begin
                bag_size = 0;
                r.ok     = 1'b1;
            end
        endcase
        r.size      = clamp_count(bag_size);
        r.empty_res = (bag_size == 0);
        return r;
    endfunction

    // Result beats are handled before input beats: a result can never belong
    // to an item accepted at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bag_size = 0;
            expected_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got      = fcm_pkg::t_result'(i_m_tdata[fcm_pkg::RESULT_W-1:0]);
                pad_bits = i_m_tdata >> fcm_pkg::RESULT_W;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: result beat with nothing expected, tdata=%h",
                                 $realtime, i_m_tdata);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got.ok !== want.ok || got.frequency !== want.frequency ||
                        got.size !== want.size || got.empty_res !== want.empty_res ||
                        pad_bits !== '0) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $write("%0t: mismatch, expected ok=%0b freq=%0d size=%0d ",
                                   $realtime, want.ok, want.frequency, want.size);
                            $write("empty=%0b pad=0, ", want.empty_res);
                            $display("got ok=%0b freq=%0d size=%0d empty=%0b pad=%0h",
                                     got.ok, got.frequency, got.size, got.empty_res,
                                     pad_bits);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predicted = bag_predict(fcm_pkg::t_func'(i_s_tuser), i_s_tdata);
                expected_results.insert(expected_results.size(), predicted);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_results.size();
    end

endmodule

// ----- dv/tb.sv -----
// Testbench top for the fixed-capacity multiset: clock, reset, input beats,
// result-side backpressure and the verdict.
// Depends on fcm_pkg, fixed_capacity_multiset_top and multiset_checker.
module tb;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int POOL_SIZE    = 5;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [31:0]                     s_tdata;
    logic [1:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [fcm_pkg::TDATA_OUT_W-1:0] m_tdata;
    int                              fail_count;
    int                              pending;

    // Idle percentages and the current traffic phase.
    int                     send_idle_pct = 20;
    int                     recv_idle_pct = 49;
    int                     phase = 0;
    logic [31:0]            value_pool [POOL_SIZE];

    fixed_capacity_multiset_top #(
        .CAPACITY    (CAPACITY),
        .ENTRY_WIDTH (32)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    multiset_checker #(
        .CAPACITY    (CAPACITY),
        .ENTRY_WIDTH (32)
    ) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Offer one beat, with random idle cycles first, and wait for acceptance.
    task automatic send_item(fcm_pkg::t_func func, logic [31:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= func;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Mostly values from a small pool so that adds, removes and counts collide.
    task automatic send_random_item();
        fcm_pkg::t_func func;
        logic [31:0]    value;
        int             pick;
        pick = $urandom_range(99);
        if (pick < 40) func = fcm_pkg::FUNC_ADD;
        else if (pick < 65) func = fcm_pkg::FUNC_REMOVE;
        else if (pick < 95) func = fcm_pkg::FUNC_COUNT;
        else func = fcm_pkg::FUNC_CLEAR;
        pick = $urandom_range(99);
        if (pick < 75) value = value_pool[$urandom_range(POOL_SIZE - 1)];
        else if (pick < 80) value = 32'h0000_0000;
        else if (pick < 85) value = 32'hFFFF_FFFF;
        else value = $urandom;
        // Now and then swap a pool entry for a fresh value.
        if ($urandom_range(99) < 4) value_pool[$urandom_range(POOL_SIZE - 1)] = $urandom;
        send_item(func, value);
    endtask

    // Result side: random stalls, plus one long hold-off when the last phase starts.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (phase == 2 && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Reset, stimulus and verdict.
    initial begin
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= fcm_pkg::FUNC_ADD;
        rst_n    <= 1'b0;
        value_pool[0] = $urandom;
        // Near misses: neighbors of the first value differ in a single bit.
        value_pool[1] = value_pool[0] ^ (32'd1 << $urandom_range(31));
        value_pool[2] = value_pool[0] ^ (32'd1 << $urandom_range(31));
        value_pool[3] = $urandom;
        value_pool[4] = $urandom;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty bag: count and remove find nothing.
        send_item(fcm_pkg::FUNC_COUNT, 32'h0000_0000);
        send_item(fcm_pkg::FUNC_REMOVE, 32'h0000_0000);
        // Extreme values and a duplicate.
        send_item(fcm_pkg::FUNC_ADD, 32'h0000_0000);
        send_item(fcm_pkg::FUNC_ADD, 32'hFFFF_FFFF);
        send_item(fcm_pkg::FUNC_ADD, 32'h0000_0000);
        send_item(fcm_pkg::FUNC_COUNT, 32'h0000_0000);
        // Remove the first entry so the last one moves in, then the last itself.
        send_item(fcm_pkg::FUNC_REMOVE, 32'h0000_0000);
        send_item(fcm_pkg::FUNC_REMOVE, 32'hFFFF_FFFF);
        send_item(fcm_pkg::FUNC_REMOVE, 32'h1234_5678);
        // Fill to capacity with one value, try one more, count all of them.
        repeat (CAPACITY - 1) send_item(fcm_pkg::FUNC_ADD, 32'h0000_0000);
        send_item(fcm_pkg::FUNC_ADD, 32'hFFFF_FFFF);
        send_item(fcm_pkg::FUNC_COUNT, 32'h0000_0000);
        send_item(fcm_pkg::FUNC_CLEAR, 32'hA5A5_A5A5);

        // Random traffic in three idling phases.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 150) begin
                send_idle_pct = 49;
                recv_idle_pct = 20;
                phase = 1;
            end else if (n == 320) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                phase = 2;
            end
            send_random_item();
        end
        s_tvalid <= 1'b0;
        @(posedge clk);

        // Drain outstanding results, then watch for stray beats.
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
